@@ sv/psa_pkg.sv @@
// Shared types and constants for the power sample scaler with autoranging.
// Used by the serial multiplier and by the top level; no dependencies.
package psa_pkg;

  localparam int MUL_A_W   = 40;               // multiplicand width
  localparam int MUL_B_W   = 16;               // multiplier width, one bit per cycle
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] RANGE_40MV  = 2'd0;
  localparam logic [1:0] RANGE_80MV  = 2'd1;
  localparam logic [1:0] RANGE_160MV = 2'd2;
  localparam logic [1:0] RANGE_320MV = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_WIDEST       = 3'd0,
    REG_UP_WIDE         = 3'd1,
    REG_UP_NARROW       = 3'd2,
    REG_DOWN_WIDE       = 3'd3,
    REG_DOWN_NARROW     = 3'd4,
    REG_DOWN_NARROWEST  = 3'd5,
    REG_CURRENT_SCALE   = 3'd6,
    REG_CURRENT_OFFSET  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_CURRENT,
    ST_OFFSET,
    ST_MUL_POWER,
    ST_FINISH
  } psa_state_t;

  typedef struct packed {
    logic start;
    logic b_signed;
  } mul_ctl_t;

endpackage

@@ sv/psa_serial_mul.sv @@
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Multiplier may be two's complement (top bit weighs negative). Uses psa_pkg.
module psa_serial_mul
  import psa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mul_ctl_t           ctl,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod,
  output logic               done
);

  localparam int ACC_W = MUL_A_W + 2;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [MUL_B_W-1:0]      lo_r, lo_nxt;
  logic [MUL_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic                    signed_r, signed_nxt;
  logic [MUL_A_W-1:0]      a_r, a_nxt;

  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] sum;
  logic                    last;

  assign last = (cnt_r == MUL_CNT_W'(MUL_B_W - 1));

  always_comb begin
    addend = '0;
    if (lo_r[0]) begin
      if (last && signed_r) begin
        addend = -$signed({2'b00, a_r});
      end else begin
        addend = $signed({2'b00, a_r});
      end
    end
    sum = acc_r + addend;
  end

  always_comb begin
    acc_nxt    = acc_r;
    lo_nxt     = lo_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    signed_nxt = signed_r;
    a_nxt      = a_r;
    if (ctl.start) begin
      acc_nxt    = '0;
      lo_nxt     = b;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
      signed_nxt = ctl.b_signed;
      a_nxt      = a;
    end else if (busy_r) begin
      // product low bits shift in as multiplier bits shift out
      acc_nxt = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + MUL_CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    lo_r     <= lo_nxt;
    signed_r <= signed_nxt;
    a_r      <= a_nxt;
  end

  assign prod = {acc_r[MUL_A_W-1:0], lo_r};
  assign done = done_r;

endmodule

@@ sv/power_sample_scaler_autorange.sv @@
// Top level of the power sample scaler with shunt gain autoranging.
// Depends on psa_pkg and psa_serial_mul.
//
// Usage:
//   Input channel in_* carries one raw sample (bus word, shunt code, current
//   code); a transfer happens when in_valid is high and in_stall is low.
//   Output channel out_* carries one result per sample, held in an output
//   register until the receiver takes it (out_valid high, out_stall low).
//   cfg_write_en writes cfg_data into register cfg_index; write only while
//   no sample is in flight.
//   Steps: one serial multiplier, one bit per cycle, computes the current,
//   then an offset step subtracts the offset and starts the power multiply,
//   then a commit step writes the output register.
//   A new sample is taken only after the last one is committed; control
//   passes through idle between samples, and the next sample is taken while
//   a finished result still waits at the output.
//   If the receiver stalls, the block finishes the next sample and holds it
//   in the commit step until the output register frees up.
//   Reset: range goes to 320 mV, registers to their defaults, no result.
module power_sample_scaler_autorange
  import psa_pkg::*;
#(
  parameter int BUS_MV_PER_LSB = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_bus_word,
  input  logic signed [15:0]    in_shunt_code,
  input  logic signed [15:0]    in_current_code,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_bus_millivolts,
  output logic signed [15:0]    out_shunt_value,
  output logic [39:0]           out_current_ma_q16,
  output logic [38:0]           out_power_microwatts,
  output logic                  out_overflow_flag,
  output logic [1:0]            out_gain_range,
  output logic                  out_range_changed
);

  // configuration
  logic [15:0]        up_widest_r, up_wide_r, up_narrow_r;
  logic [15:0]        down_wide_r, down_narrow_r, down_narrowest_r;
  logic [23:0]        scale_r;
  logic signed [31:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_widest_r      <= 16'd15000;
      up_wide_r        <= 16'd7500;
      up_narrow_r      <= 16'd3500;
      down_wide_r      <= 16'd14000;
      down_narrow_r    <= 16'd7000;
      down_narrowest_r <= 16'd3000;
      scale_r          <= 24'd65536;
      offset_r         <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_UP_WIDEST:      up_widest_r      <= cfg_data[15:0];
        REG_UP_WIDE:        up_wide_r        <= cfg_data[15:0];
        REG_UP_NARROW:      up_narrow_r      <= cfg_data[15:0];
        REG_DOWN_WIDE:      down_wide_r      <= cfg_data[15:0];
        REG_DOWN_NARROW:    down_narrow_r    <= cfg_data[15:0];
        REG_DOWN_NARROWEST: down_narrowest_r <= cfg_data[15:0];
        REG_CURRENT_SCALE:  scale_r          <= cfg_data[23:0];
        REG_CURRENT_OFFSET: offset_r         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // control
  psa_state_t state_r, state_nxt;
  mul_ctl_t   mul_ctl;
  logic       mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic       in_xfer, commit;
  logic       out_valid_r, out_valid_nxt;

  // sample registers
  logic [15:0]        bus_mv_r, bus_mv_nxt;
  logic signed [15:0] shunt_r;
  logic               ovf_r;
  logic [39:0]        cur_q16_r;
  logic [1:0]         range_r, range_nxt;

  // output registers
  logic [15:0]        o_bus_mv_r;
  logic signed [15:0] o_shunt_r;
  logic [39:0]        o_cur_r;
  logic [38:0]        o_pw_r;
  logic               o_ovf_r, o_changed_r;
  logic [1:0]         o_range_r;

  logic signed [40:0] cq;
  logic [39:0]        cur_q16_c;
  logic [39:0]        pw_full;
  logic [38:0]        pw_sat;
  logic signed [16:0] shunt_ext;
  logic [16:0]        mag;

  assign in_xfer = in_valid && !in_stall;
  assign commit  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:        if (in_valid) state_nxt = ST_MUL_CURRENT;
      ST_MUL_CURRENT: if (mul_done) state_nxt = ST_OFFSET;
      ST_OFFSET:      state_nxt = ST_MUL_POWER;
      ST_MUL_POWER:   if (mul_done) state_nxt = ST_FINISH;
      ST_FINISH:      if (commit)   state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    mul_ctl.start    = 1'b0;
    mul_ctl.b_signed = 1'b0;
    mul_a            = {16'd0, scale_r};
    mul_b            = in_current_code;
    case (state_r)
      ST_IDLE: begin
        in_stall         = 1'b0;
        mul_ctl.start    = in_valid;
        mul_ctl.b_signed = 1'b1;
      end
      ST_OFFSET: begin
        mul_ctl.start = 1'b1;
        mul_a         = cur_q16_c;
        mul_b         = bus_mv_r;
      end
      default: ;
    endcase
  end

  psa_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  assign bus_mv_nxt = {3'd0, in_bus_word[15:3]} * 16'(BUS_MV_PER_LSB);

  // current product fits 40 bits signed; subtract offset, clamp at zero
  assign cq        = $signed({mul_prod[39], mul_prod[39:0]})
                   - $signed({{9{offset_r[31]}}, offset_r});
  assign cur_q16_c = cq[40] ? 40'd0 : cq[39:0];

  assign pw_full = mul_prod[MUL_P_W-1:16];
  assign pw_sat  = pw_full[39] ? {39{1'b1}} : pw_full[38:0];

  assign shunt_ext = {shunt_r[15], shunt_r};
  assign mag       = shunt_ext[16] ? 17'(-shunt_ext) : 17'(shunt_ext);

  always_comb begin
    range_nxt = range_r;
    if (ovf_r || mag > {1'b0, up_widest_r}) begin
      range_nxt = RANGE_320MV;
    end else if (mag > {1'b0, up_wide_r} && range_r < RANGE_160MV) begin
      range_nxt = RANGE_160MV;
    end else if (mag > {1'b0, up_narrow_r} && range_r < RANGE_80MV) begin
      range_nxt = RANGE_80MV;
    end
    // down rules win over any up result
    if (!ovf_r) begin
      if (range_r == RANGE_320MV && mag < {1'b0, down_wide_r}) begin
        range_nxt = RANGE_160MV;
      end else if (range_r == RANGE_160MV && mag < {1'b0, down_narrow_r}) begin
        range_nxt = RANGE_80MV;
      end else if (range_r == RANGE_80MV && mag < {1'b0, down_narrowest_r}) begin
        range_nxt = RANGE_40MV;
      end
    end
  end

  assign out_valid_nxt = commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      range_r     <= RANGE_320MV;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) range_r <= range_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bus_mv_r <= bus_mv_nxt;
      shunt_r  <= in_shunt_code;
      ovf_r    <= in_bus_word[0];
    end
    if (state_r == ST_OFFSET) cur_q16_r <= cur_q16_c;
    if (commit) begin
      o_bus_mv_r  <= bus_mv_r;
      o_shunt_r   <= shunt_r;
      o_cur_r     <= cur_q16_r;
      o_pw_r      <= pw_sat;
      o_ovf_r     <= ovf_r;
      o_range_r   <= range_nxt;
      o_changed_r <= (range_nxt != range_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_bus_millivolts   = o_bus_mv_r;
  assign out_shunt_value      = o_shunt_r;
  assign out_current_ma_q16   = o_cur_r;
  assign out_power_microwatts = o_pw_r;
  assign out_overflow_flag    = o_ovf_r;
  assign out_gain_range       = o_range_r;
  assign out_range_changed    = o_changed_r;

  // held range matches the last delivered range
  a_range_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (range_r == o_range_r))
    else $error("range state diverged from output");

  // overflow always leaves the widest range
  a_ovf_widest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_ovf_r) |-> (o_range_r == RANGE_320MV))
    else $error("overflow without widest range");

  // clamped current gives zero power
  a_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_cur_r == '0) |-> (o_pw_r == '0))
    else $error("power nonzero with zero current");

  // a committed result is held as valid in the output register
  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit lost");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for power_sample_scaler_autorange: directed and random samples,
// range predicted per transfer and compared field by field on the result channel.
// Depends on psa_pkg and the power_sample_scaler_autorange RTL.
module tb_top
  import psa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MV_PER_LSB     = 4;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [63:0] POWER_SAT = (64'd1 << 39) - 64'd1;

  typedef struct {
    logic [15:0] bus_mv;
    logic [15:0] shunt;
    logic [39:0] current;
    logic [38:0] power;
    logic        ovf;
    logic [1:0]  range;
    logic        changed;
  } sample_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [15:0]           in_bus_word = '0;
  logic signed [15:0]    in_shunt_code = '0;
  logic signed [15:0]    in_current_code = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           out_bus_millivolts;
  logic signed [15:0]    out_shunt_value;
  logic [39:0]           out_current_ma_q16;
  logic [38:0]           out_power_microwatts;
  logic                  out_overflow_flag;
  logic [1:0]            out_gain_range;
  logic                  out_range_changed;

  // predictor state and register copies
  logic [15:0]        thr [0:5];
  logic [23:0]        scale_q16;
  logic signed [31:0] offset_q16;
  logic [1:0]         range_model;

  sample_result_t pending_results[$];
  sample_result_t want;
  int             err_count = 0;
  logic           idle_en = 1'b1;
  int unsigned    hold_req = 0;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;

  power_sample_scaler_autorange #(
    .BUS_MV_PER_LSB(MV_PER_LSB)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_bus_word          (in_bus_word),
    .in_shunt_code        (in_shunt_code),
    .in_current_code      (in_current_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_bus_millivolts   (out_bus_millivolts),
    .out_shunt_value      (out_shunt_value),
    .out_current_ma_q16   (out_current_ma_q16),
    .out_power_microwatts (out_power_microwatts),
    .out_overflow_flag    (out_overflow_flag),
    .out_gain_range       (out_gain_range),
    .out_range_changed    (out_range_changed)
  );

  always #6 clk = ~clk;

  function automatic sample_result_t scale_sample(input logic [15:0] bw,
                                                  input logic signed [15:0] sc,
                                                  input logic signed [15:0] cc,
                                                  input logic [1:0] old_range);
    sample_result_t r;
    logic [31:0] mv_full;
    longint      cur_full;
    logic [63:0] prod;
    int          s;
    int          mag;
    mv_full  = (bw >> 3) * MV_PER_LSB;
    r.bus_mv = mv_full[15:0];
    r.shunt  = sc;
    r.ovf    = bw[0];
    cur_full = longint'(cc) * longint'(scale_q16) - longint'(offset_q16);
    r.current = (cur_full < 0) ? 40'd0 : cur_full[39:0];
    prod = ({48'd0, r.bus_mv} * {24'd0, r.current}) >> 16;
    r.power = (prod > POWER_SAT) ? POWER_SAT[38:0] : prod[38:0];

    s   = sc;
    mag = (s < 0) ? -s : s;
    r.range = old_range;
    if (r.ovf || mag > int'(thr[REG_UP_WIDEST]))
      r.range = RANGE_320MV;
    else if (mag > int'(thr[REG_UP_WIDE]) && old_range < RANGE_160MV)
      r.range = RANGE_160MV;
    else if (mag > int'(thr[REG_UP_NARROW]) && old_range < RANGE_80MV)
      r.range = RANGE_80MV;
    // down rules look at the old range and win over any step up
    if (!r.ovf) begin
      if (old_range == RANGE_320MV && mag < int'(thr[REG_DOWN_WIDE]))
        r.range = RANGE_160MV;
      else if (old_range == RANGE_160MV && mag < int'(thr[REG_DOWN_NARROW]))
        r.range = RANGE_80MV;
      else if (old_range == RANGE_80MV && mag < int'(thr[REG_DOWN_NARROWEST]))
        r.range = RANGE_40MV;
    end
    r.changed = (r.range != old_range);
    return r;
  endfunction

  task automatic reset_model();
    thr[REG_UP_WIDEST]      = 16'd15000;
    thr[REG_UP_WIDE]        = 16'd7500;
    thr[REG_UP_NARROW]      = 16'd3500;
    thr[REG_DOWN_WIDE]      = 16'd14000;
    thr[REG_DOWN_NARROW]    = 16'd7000;
    thr[REG_DOWN_NARROWEST] = 16'd3000;
    scale_q16   = 24'd65536;
    offset_q16  = '0;
    range_model = RANGE_320MV;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CURRENT_SCALE:  scale_q16 = val[23:0];
      REG_CURRENT_OFFSET: offset_q16 = val;
      default:            thr[idx] = val[15:0];
    endcase
  endtask

  // returns right after the accepting edge; in_valid stays high for the next call
  task automatic send_sample(input logic [15:0] bw, input logic [15:0] sc,
                             input logic [15:0] cc);
    sample_result_t predicted;
    if (idle_en) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_bus_word     <= bw;
    in_shunt_code   <= sc;
    in_current_code <= cc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted   = scale_sample(bw, sc, cc, range_model);
    range_model = predicted.range;
    pending_results.push_back(predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_bus();
    logic [15:0] bw;
    bw    = 16'($urandom_range(65535));
    bw[0] = ($urandom_range(9) == 0);
    return bw;
  endfunction

  // half of the picks are magnitudes close to a threshold so the range keeps moving
  function automatic logic [15:0] pick_shunt();
    int          mag;
    logic [15:0] v;
    case ($urandom_range(3))
      0:       return 16'($urandom_range(65535));
      1:       mag = $urandom_range(3000);
      default: mag = int'(thr[3'($urandom_range(5))]) + int'($urandom_range(8)) - 4;
    endcase
    if (mag < 0) mag = 0;
    if (mag > 32767) return 16'h8000;
    v = 16'(($urandom_range(1) != 0) ? -mag : mag);
    return v;
  endfunction

  function automatic logic [15:0] pick_current();
    logic [15:0] v;
    if ($urandom_range(1) != 0) v = 16'($urandom_range(65535));
    else v = 16'(int'($urandom_range(2000)) - 1000);
    return v;
  endfunction

  task automatic random_config();
    logic [15:0] level [0:5];
    logic [31:0] scale_val;
    logic [31:0] offset_val;
    if ($urandom_range(3) == 0) begin
      foreach (level[i]) level[i] = 16'($urandom_range(32768));
    end else begin
      // ordered with hysteresis gaps
      level[REG_DOWN_NARROWEST] = 16'($urandom_range(200, 8000));
      level[REG_UP_NARROW]      = 16'(level[REG_DOWN_NARROWEST] + $urandom_range(50, 2000));
      level[REG_DOWN_NARROW]    = 16'(level[REG_UP_NARROW] + $urandom_range(100, 6000));
      level[REG_UP_WIDE]        = 16'(level[REG_DOWN_NARROW] + $urandom_range(50, 2000));
      level[REG_DOWN_WIDE]      = 16'(level[REG_UP_WIDE] + $urandom_range(100, 8000));
      level[REG_UP_WIDEST]      = 16'(level[REG_DOWN_WIDE] + $urandom_range(50, 2000));
    end
    foreach (level[i])
      if ($urandom_range(7) == 0) level[i] = ($urandom_range(1) != 0) ? 16'h8000 : 16'h0000;
    scale_val = ($urandom_range(1) != 0) ? $urandom_range(16777215) : $urandom_range(131072);
    if ($urandom_range(7) == 0) scale_val = ($urandom_range(1) != 0) ? 32'hFF_FFFF : 32'h0;
    offset_val = ($urandom_range(1) != 0) ? $urandom : int'($urandom_range(2000000)) - 1000000;
    if ($urandom_range(7) == 0)
      offset_val = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_t'(i), {16'd0, level[i]});
    write_reg(REG_CURRENT_SCALE, scale_val);
    write_reg(REG_CURRENT_OFFSET, offset_val);
  endtask

  // reset thresholds: walk the range down to 40 mV and back up, then field extremes
  task automatic test_default_range_walk();
    send_sample(16'h0000, 16'd0, 16'd0);
    send_sample(16'h0008, 16'd0, 16'd1);
    send_sample(16'h0010, 16'd0, 16'hFFFF);
    send_sample(16'h0000, 16'd4000, 16'd100);
    send_sample(16'h1234, 16'hE0C0, 16'h7FFF);
    send_sample(16'h0000, 16'd16000, 16'd0);
    send_sample(16'hFFF8, 16'h7FFF, 16'h7FFF);
    send_sample(16'hFFF8, 16'h8000, 16'h8000);
    send_sample(16'h0001, 16'd100, 16'd5);
    send_sample(16'h5550, 16'd14000, 16'd0);
    send_sample(16'hAAAF, 16'd0, 16'h5555);
    send_sample(16'h5550, 16'd13999, 16'hAAAA);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // max scale, most negative offset; crossed thresholds so down undoes up
    write_reg(REG_UP_WIDEST, 32'h8000);
    write_reg(REG_UP_WIDE, 32'h0);
    write_reg(REG_UP_NARROW, 32'h0);
    write_reg(REG_DOWN_WIDE, 32'h8000);
    write_reg(REG_DOWN_NARROW, 32'h0);
    write_reg(REG_DOWN_NARROWEST, 32'h8000);
    write_reg(REG_CURRENT_SCALE, 32'hFF_FFFF);
    write_reg(REG_CURRENT_OFFSET, 32'h8000_0000);
    send_sample(16'hFFF8, 16'h7FFF, 16'h7FFF);
    send_sample(16'hFFF8, 16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0001, 16'h8000);
    send_sample(16'h0008, 16'h0000, 16'h0001);
    wait_drained();
    // zero scale, max offset, every threshold at zero
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_t'(i), 32'h0);
    write_reg(REG_CURRENT_SCALE, 32'h0);
    write_reg(REG_CURRENT_OFFSET, 32'h7FFF_FFFF);
    send_sample(16'hFFF8, 16'h0001, 16'h7FFF);
    send_sample(16'h0000, 16'h0000, 16'h8000);
    send_sample(16'hFFFE, 16'h8000, 16'h0000);
    wait_drained();
    write_reg(REG_CURRENT_OFFSET, 32'hFFFF_FFFF);
    send_sample(16'hFFF8, 16'h0000, 16'h1234);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 8; round++) begin
      random_config();
      idle_en = (round != 0);
      if (round == 2) hold_req++;   // long receiver hold-off while samples keep coming
      repeat (50) send_sample(pick_bus(), pick_shunt(), pick_current());
      wait_drained();
    end
    idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 20);
    end
  end

  task automatic flag_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s expected %0h got %0h", $realtime, field, exp_v, act_v);
  endtask

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) flag_mismatch(field, exp_v, act_v);
  endtask

  // fields are compared as raw bit patterns, zero-extended
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected transfer, bus_millivolts", 64'd0,
                      64'(out_bus_millivolts));
      end else begin
        want = pending_results.pop_front();
        check_field("bus_millivolts", 64'(want.bus_mv), 64'(out_bus_millivolts));
        check_field("shunt_value", 64'(want.shunt), 64'($unsigned(out_shunt_value)));
        check_field("current_ma_q16", 64'(want.current), 64'(out_current_ma_q16));
        check_field("power_microwatts", 64'(want.power), 64'(out_power_microwatts));
        check_field("overflow_flag", 64'(want.ovf), 64'(out_overflow_flag));
        check_field("gain_range", 64'(want.range), 64'(out_gain_range));
        check_field("range_changed", 64'(want.changed), 64'(out_range_changed));
      end
    end
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_range_walk();
    test_register_extremes();
    test_random_traffic();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
